/* rtl/i2cbe_pkg.sv */
// i2cbe_pkg: shared types and constants of the i2c master bit engine
// no dependencies; used by the channel interfaces, the core and the top level

package i2cbe_pkg;

	localparam int CmdW   = 3;
	localparam int ByteW  = 8;
	localparam int CntW   = 4;
	localparam int TimerW = 8;

	// reset value of the phase length register
	localparam logic [TimerW-1:0] PhaseTicksReset = TimerW'(10);
	// bits in one byte on the wire
	localparam logic [CntW-1:0]   BitsPerByte     = CntW'(8);

	// command codes carried by a tick; other codes do nothing
	typedef enum logic [CmdW-1:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_STOP    = 3'd2,
		CMD_WRITE   = 3'd3,
		CMD_READ    = 3'd4,
		CMD_RELEASE = 3'd5
	} cmd_t;

	// sequencer steps, one-hot
	typedef enum logic [16:0] {
		ST_IDLE  = 17'h00001,
		ST_FIN   = 17'h00002,
		ST_ST1   = 17'h00004,
		ST_ST2   = 17'h00008,
		ST_ST3   = 17'h00010,
		ST_SP1   = 17'h00020,
		ST_SP2   = 17'h00040,
		ST_SP3   = 17'h00080,
		ST_WHI   = 17'h00100,
		ST_WLO   = 17'h00200,
		ST_WAHI  = 17'h00400,
		ST_WASMP = 17'h00800,
		ST_WREL  = 17'h01000,
		ST_RNEXT = 17'h02000,
		ST_RSMP  = 17'h04000,
		ST_RAHI  = 17'h08000,
		ST_RALO  = 17'h10000
	} step_t;

	// one tick as it enters the engine
	typedef struct packed {
		logic [CmdW-1:0]  cmd;
		logic [ByteW-1:0] tx_byte;
		logic             send_nack;
		logic             sda_in;
	} item_t;

	// one result as it leaves the engine
	typedef struct packed {
		logic             scl_level;
		logic             sda_level;
		logic             sda_drive;
		logic             scl_drive;
		logic             busy_res;
		logic             done_res;
		logic             nacked;
		logic [ByteW-1:0] rx_byte;
	} res_t;

endpackage

/* rtl/i2cbe_tick_if.sv */
// i2cbe_tick_if: input channel of the bit engine, one tick per transfer
// depends on i2cbe_pkg for the field widths

interface i2cbe_tick_if;
	logic                          valid;
	logic                          ready;
	logic [i2cbe_pkg::CmdW-1:0]    cmd;
	logic [i2cbe_pkg::ByteW-1:0]   tx_byte;
	logic                          send_nack;
	logic                          sda_in;

	modport source (output valid, cmd, tx_byte, send_nack, sda_in, input ready);
	modport sink (input valid, cmd, tx_byte, send_nack, sda_in, output ready);
endinterface

/* rtl/i2cbe_res_if.sv */
// i2cbe_res_if: result channel of the bit engine, one result per transfer
// depends on i2cbe_pkg for the field widths

interface i2cbe_res_if;
	logic                          valid;
	logic                          ready;
	logic                          scl_level;
	logic                          sda_level;
	logic                          sda_drive;
	logic                          scl_drive;
	logic                          busy_res;
	logic                          done_res;
	logic                          nacked;
	logic [i2cbe_pkg::ByteW-1:0]   rx_byte;

	modport source (output valid, scl_level, sda_level, sda_drive, scl_drive,
		busy_res, done_res, nacked, rx_byte, input ready);
	modport sink (input valid, scl_level, sda_level, sda_drive, scl_drive,
		busy_res, done_res, nacked, rx_byte, output ready);
endinterface

/* rtl/i2cbe_core.sv */
// i2cbe_core: sequencer state of the bit engine and its per-tick update
// depends on i2cbe_pkg; the result is combinational and registered by the top level

module i2cbe_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fire,
	input  i2cbe_pkg::item_t                   item,
	input  logic [i2cbe_pkg::TimerW-1:0]       phase_ticks,
	output i2cbe_pkg::res_t                    res
);

	i2cbe_pkg::step_t                  step_q, step_d;
	logic [i2cbe_pkg::TimerW-1:0]      timer_q, timer_d;
	logic [i2cbe_pkg::CntW-1:0]        bit_cnt_q, bit_cnt_d;
	logic [i2cbe_pkg::ByteW-1:0]       shift_q, shift_d;
	logic                              ack_q, ack_d;
	logic                              scl_q, scl_d;
	logic                              sda_q, sda_d;
	logic                              sdae_q, sdae_d;
	logic                              scle_q, scle_d;
	logic                              nack_q, nack_d;
	logic [i2cbe_pkg::ByteW-1:0]       rx_q, rx_d;
	logic                              done;

	// phase length, zero acts as one
	logic [i2cbe_pkg::TimerW-1:0]      phase_len;
	logic [i2cbe_pkg::CntW-1:0]        bit_inc;
	logic [i2cbe_pkg::ByteW-1:0]       shift_wr;
	logic [i2cbe_pkg::ByteW-1:0]       shift_rd;

	assign phase_len = (phase_ticks == '0) ? i2cbe_pkg::TimerW'(1) : phase_ticks;
	assign bit_inc   = bit_cnt_q + i2cbe_pkg::CntW'(1);
	assign shift_wr  = {shift_q[i2cbe_pkg::ByteW-2:0], 1'b0};
	assign shift_rd  = {shift_q[i2cbe_pkg::ByteW-2:0], item.sda_in};

	// next state for one tick
	always_comb begin
		step_d    = step_q;
		timer_d   = timer_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		ack_d     = ack_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		sdae_d    = sdae_q;
		scle_d    = scle_q;
		nack_d    = nack_q;
		rx_d      = rx_q;
		done      = 1'b0;
		if (step_q == i2cbe_pkg::ST_IDLE) begin
			// command decode while idle
			case (item.cmd)
				i2cbe_pkg::CMD_START: begin
					sda_d   = 1'b1;
					step_d  = i2cbe_pkg::ST_ST1;
					timer_d = phase_len;
				end
				i2cbe_pkg::CMD_STOP: begin
					sda_d   = 1'b0;
					step_d  = i2cbe_pkg::ST_SP1;
					timer_d = phase_len;
				end
				i2cbe_pkg::CMD_WRITE: begin
					shift_d   = item.tx_byte;
					bit_cnt_d = '0;
					sda_d     = item.tx_byte[i2cbe_pkg::ByteW-1];
					step_d    = i2cbe_pkg::ST_WHI;
					timer_d   = phase_len;
				end
				i2cbe_pkg::CMD_READ: begin
					shift_d   = '0;
					bit_cnt_d = '0;
					ack_d     = item.send_nack;
					sdae_d    = 1'b0;
					step_d    = i2cbe_pkg::ST_RNEXT;
					timer_d   = phase_len;
				end
				i2cbe_pkg::CMD_RELEASE: begin
					sdae_d = 1'b0;
					scle_d = 1'b0;
					done   = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (timer_q > i2cbe_pkg::TimerW'(1)) begin
			// phase still running
			timer_d = timer_q - i2cbe_pkg::TimerW'(1);
		end else begin
			// phase expired: do the next pin action
			timer_d = phase_len;
			case (step_q)
				i2cbe_pkg::ST_ST1: begin
					scl_d  = 1'b1;
					step_d = i2cbe_pkg::ST_ST2;
				end
				i2cbe_pkg::ST_ST2: begin
					sda_d  = 1'b0;
					step_d = i2cbe_pkg::ST_ST3;
				end
				i2cbe_pkg::ST_ST3: begin
					scl_d  = 1'b0;
					step_d = i2cbe_pkg::ST_FIN;
				end
				i2cbe_pkg::ST_SP1: begin
					scl_d  = 1'b1;
					step_d = i2cbe_pkg::ST_SP2;
				end
				i2cbe_pkg::ST_SP2: begin
					sda_d  = 1'b1;
					step_d = i2cbe_pkg::ST_SP3;
				end
				i2cbe_pkg::ST_SP3: begin
					scl_d  = 1'b0;
					step_d = i2cbe_pkg::ST_FIN;
				end
				i2cbe_pkg::ST_WHI: begin
					scl_d  = 1'b1;
					step_d = i2cbe_pkg::ST_WLO;
				end
				i2cbe_pkg::ST_WLO: begin
					scl_d     = 1'b0;
					bit_cnt_d = bit_inc;
					shift_d   = shift_wr;
					if (bit_inc < i2cbe_pkg::BitsPerByte) begin
						sda_d  = shift_wr[i2cbe_pkg::ByteW-1];
						step_d = i2cbe_pkg::ST_WHI;
					end else begin
						sdae_d = 1'b0;
						step_d = i2cbe_pkg::ST_WAHI;
					end
				end
				i2cbe_pkg::ST_WAHI: begin
					scl_d  = 1'b1;
					step_d = i2cbe_pkg::ST_WASMP;
				end
				i2cbe_pkg::ST_WASMP: begin
					// sample acknowledge; a nack runs a stop
					if (item.sda_in) begin
						nack_d = 1'b1;
						sda_d  = 1'b0;
						sdae_d = 1'b1;
						step_d = i2cbe_pkg::ST_SP1;
					end else begin
						nack_d = 1'b0;
						scl_d  = 1'b0;
						step_d = i2cbe_pkg::ST_WREL;
					end
				end
				i2cbe_pkg::ST_WREL: begin
					sda_d  = 1'b0;
					sdae_d = 1'b1;
					step_d = i2cbe_pkg::ST_FIN;
				end
				i2cbe_pkg::ST_RNEXT: begin
					if (bit_cnt_q < i2cbe_pkg::BitsPerByte) begin
						scl_d  = 1'b1;
						step_d = i2cbe_pkg::ST_RSMP;
					end else begin
						sda_d  = ack_q;
						sdae_d = 1'b1;
						step_d = i2cbe_pkg::ST_RAHI;
					end
				end
				i2cbe_pkg::ST_RSMP: begin
					shift_d   = shift_rd;
					scl_d     = 1'b0;
					bit_cnt_d = bit_inc;
					if (bit_inc >= i2cbe_pkg::BitsPerByte) begin
						rx_d = shift_rd;
					end
					step_d = i2cbe_pkg::ST_RNEXT;
				end
				i2cbe_pkg::ST_RAHI: begin
					scl_d  = 1'b1;
					step_d = i2cbe_pkg::ST_RALO;
				end
				i2cbe_pkg::ST_RALO: begin
					scl_d  = 1'b0;
					step_d = i2cbe_pkg::ST_FIN;
				end
				default: begin
					// end of sequence
					step_d  = i2cbe_pkg::ST_IDLE;
					timer_d = '0;
					done    = 1'b1;
				end
			endcase
		end
	end

	// result fields after this tick
	always_comb begin
		res.scl_level = scl_d;
		res.sda_level = sda_d;
		res.sda_drive = sdae_d;
		res.scl_drive = scle_d;
		res.busy_res  = (step_d != i2cbe_pkg::ST_IDLE);
		res.done_res  = done;
		res.nacked    = nack_d;
		res.rx_byte   = rx_d;
	end

	// state registers, updated once per consumed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= i2cbe_pkg::ST_IDLE;
			timer_q   <= '0;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			ack_q     <= 1'b0;
			scl_q     <= 1'b0;
			sda_q     <= 1'b0;
			sdae_q    <= 1'b1;
			scle_q    <= 1'b1;
			nack_q    <= 1'b0;
			rx_q      <= '0;
		end else if (fire) begin
			step_q    <= step_d;
			timer_q   <= timer_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			ack_q     <= ack_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
			sdae_q    <= sdae_d;
			scle_q    <= scle_d;
			nack_q    <= nack_d;
			rx_q      <= rx_d;
		end
	end

endmodule

/* rtl/i2c_master_bit_engine.sv */
// i2c_master_bit_engine: top level with tick input register, result register and config
// depends on i2cbe_pkg, i2cbe_tick_if, i2cbe_res_if and i2cbe_core

// One tick is taken every clock cycle while results are being taken. A tick passes an
// input register, one pass of the sequencer logic in i2cbe_core, and a result register,
// so its result is offered from the result register. Every tick gives exactly one
// result: the pin levels and output enables after that tick, busy and done flags, the
// acknowledge of the last write and the byte of the last read. A command is only acted
// on when the engine is idle; each pin action is followed by phase_ticks ticks (zero
// counts as one). After reset both pins are driven low. Write phase_ticks only while
// no ticks are in flight.

module i2c_master_bit_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	i2cbe_tick_if.sink                       tick,
	i2cbe_res_if.source                      result,
	input  logic                             cfg_wr_en,
	input  logic [i2cbe_pkg::TimerW-1:0]     cfg_wr_data
);

	logic [i2cbe_pkg::TimerW-1:0] phase_ticks_q;
	i2cbe_pkg::item_t             item_s1;
	logic                         vld_s1;
	i2cbe_pkg::res_t              res_d;
	i2cbe_pkg::res_t              res_s2;
	logic                         vld_s2;
	logic                         s2_free;
	logic                         adv;

	// handshake between stages
	assign s2_free    = !vld_s2 || result.ready;
	assign adv        = vld_s1 && s2_free;
	assign tick.ready = !vld_s1 || s2_free;

	// phase length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cbe_pkg::PhaseTicksReset;
		end else if (cfg_wr_en) begin
			phase_ticks_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (tick.valid && tick.ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1.cmd       <= tick.cmd;
			item_s1.tx_byte   <= tick.tx_byte;
			item_s1.send_nack <= tick.send_nack;
			item_s1.sda_in    <= tick.sda_in;
		end
	end

	// sequencer
	i2cbe_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv),
		.item        (item_s1),
		.phase_ticks (phase_ticks_q),
		.res         (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (result.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid     = vld_s2;
	assign result.scl_level = res_s2.scl_level;
	assign result.sda_level = res_s2.sda_level;
	assign result.sda_drive = res_s2.sda_drive;
	assign result.scl_drive = res_s2.scl_drive;
	assign result.busy_res  = res_s2.busy_res;
	assign result.done_res  = res_s2.done_res;
	assign result.nacked    = res_s2.nacked;
	assign result.rx_byte   = res_s2.rx_byte;

`ifndef ASSERT_OFF
	// a finishing tick always leaves the sequencer idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_d.done_res |-> !res_d.busy_res)
		else $error("done with sequencer still busy");

	// a consumed tick always lands in the result register
	a_adv_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> vld_s2)
		else $error("consumed tick lost before result register");

	// a stalled result is not overwritten
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !result.ready |=> vld_s2 && res_s2 == $past(res_s2))
		else $error("stalled result changed");
`endif

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for the i2c master bit engine, ticks in and pin results out
// predicts every result with its own sequencer copy; needs i2cbe_pkg, both channel
// interfaces and the i2c_master_bit_engine top level

module testbench;

	// sda_in patterns while a command runs
	localparam int SdaLow  = 0;
	localparam int SdaHigh = 1;
	localparam int SdaRand = 2;

	// idling modes of the two channels
	localparam int IdleNone     = 0;
	localparam int IdleSender   = 1;
	localparam int IdleReceiver = 2;
	localparam int IdleBoth     = 3;

	// codes outside the command set
	localparam logic [i2cbe_pkg::CmdW-1:0] CmdSpare6 = 3'd6;
	localparam logic [i2cbe_pkg::CmdW-1:0] CmdSpare7 = 3'd7;

	localparam int StallLimit = 2000;
	localparam int PhaseTicks = 125;

	// expected pin results and the sequencer that produces them
	class engine_scoreboard;
		i2cbe_pkg::res_t              pending_results[$];
		i2cbe_pkg::step_t             step;
		logic [i2cbe_pkg::TimerW-1:0] phase_len;
		logic [i2cbe_pkg::TimerW-1:0] timer;
		logic [i2cbe_pkg::CntW-1:0]   bit_cnt;
		logic [i2cbe_pkg::ByteW-1:0]  shreg;
		logic                         ack_bit;
		logic                         scl, sda, sda_en, scl_en;
		logic                         nack_flag;
		logic [i2cbe_pkg::ByteW-1:0]  rx_hold;
		int                           errors;
		int                           checked;
		int                           ticks;
		int                           nack_events;
		int                           cmd_seen[8];

		function new();
			phase_len   = i2cbe_pkg::PhaseTicksReset;
			step        = i2cbe_pkg::ST_IDLE;
			timer       = '0;
			bit_cnt     = '0;
			shreg       = '0;
			ack_bit     = 1'b0;
			scl         = 1'b0;
			sda         = 1'b0;
			sda_en      = 1'b1;
			scl_en      = 1'b1;
			nack_flag   = 1'b0;
			rx_hold     = '0;
			errors      = 0;
			checked     = 0;
			ticks       = 0;
			nack_events = 0;
			foreach (cmd_seen[i]) cmd_seen[i] = 0;
		endfunction

		function void set_phase(logic [i2cbe_pkg::TimerW-1:0] value);
			phase_len = value;
		endfunction

		function bit idle();
			return step == i2cbe_pkg::ST_IDLE;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// enter a step and start its timing phase, zero length counts as one
		function void go(i2cbe_pkg::step_t nxt);
			step  = nxt;
			timer = (phase_len != '0) ? phase_len : i2cbe_pkg::TimerW'(1);
		endfunction

		// pin action at the end of a phase, returns 1 when the sequence ends
		function bit advance(logic sda_s);
			case (step)
				i2cbe_pkg::ST_ST1: begin scl = 1'b1; go(i2cbe_pkg::ST_ST2); end
				i2cbe_pkg::ST_ST2: begin sda = 1'b0; go(i2cbe_pkg::ST_ST3); end
				i2cbe_pkg::ST_ST3: begin scl = 1'b0; go(i2cbe_pkg::ST_FIN); end
				i2cbe_pkg::ST_SP1: begin scl = 1'b1; go(i2cbe_pkg::ST_SP2); end
				i2cbe_pkg::ST_SP2: begin sda = 1'b1; go(i2cbe_pkg::ST_SP3); end
				i2cbe_pkg::ST_SP3: begin scl = 1'b0; go(i2cbe_pkg::ST_FIN); end
				i2cbe_pkg::ST_WHI: begin scl = 1'b1; go(i2cbe_pkg::ST_WLO); end
				i2cbe_pkg::ST_WLO: begin
					scl     = 1'b0;
					bit_cnt = bit_cnt + i2cbe_pkg::CntW'(1);
					shreg   = shreg << 1;
					if (bit_cnt < i2cbe_pkg::BitsPerByte) begin
						sda = shreg[i2cbe_pkg::ByteW-1];
						go(i2cbe_pkg::ST_WHI);
					end else begin
						sda_en = 1'b0;
						go(i2cbe_pkg::ST_WAHI);
					end
				end
				i2cbe_pkg::ST_WAHI: begin scl = 1'b1; go(i2cbe_pkg::ST_WASMP); end
				i2cbe_pkg::ST_WASMP: begin
					// slave nack: drive sda low and run a stop
					if (sda_s) begin
						nack_flag = 1'b1;
						nack_events++;
						sda       = 1'b0;
						sda_en    = 1'b1;
						go(i2cbe_pkg::ST_SP1);
					end else begin
						nack_flag = 1'b0;
						scl       = 1'b0;
						go(i2cbe_pkg::ST_WREL);
					end
				end
				i2cbe_pkg::ST_WREL: begin
					sda    = 1'b0;
					sda_en = 1'b1;
					go(i2cbe_pkg::ST_FIN);
				end
				i2cbe_pkg::ST_RNEXT: begin
					if (bit_cnt < i2cbe_pkg::BitsPerByte) begin
						scl = 1'b1;
						go(i2cbe_pkg::ST_RSMP);
					end else begin
						sda    = ack_bit;
						sda_en = 1'b1;
						go(i2cbe_pkg::ST_RAHI);
					end
				end
				i2cbe_pkg::ST_RSMP: begin
					shreg   = {shreg[i2cbe_pkg::ByteW-2:0], sda_s};
					scl     = 1'b0;
					bit_cnt = bit_cnt + i2cbe_pkg::CntW'(1);
					if (bit_cnt >= i2cbe_pkg::BitsPerByte)
						rx_hold = shreg;
					go(i2cbe_pkg::ST_RNEXT);
				end
				i2cbe_pkg::ST_RAHI: begin scl = 1'b1; go(i2cbe_pkg::ST_RALO); end
				i2cbe_pkg::ST_RALO: begin scl = 1'b0; go(i2cbe_pkg::ST_FIN); end
				default: begin
					step  = i2cbe_pkg::ST_IDLE;
					timer = '0;
					return 1'b1;
				end
			endcase
			return 1'b0;
		endfunction

		// one accepted tick: update the sequencer and queue the result it gives
		function void note_tick(i2cbe_pkg::item_t it);
			i2cbe_pkg::res_t want;
			logic done;
			done = 1'b0;
			ticks++;
			if (step == i2cbe_pkg::ST_IDLE) begin
				cmd_seen[it.cmd]++;
				case (it.cmd)
					i2cbe_pkg::CMD_START: begin sda = 1'b1; go(i2cbe_pkg::ST_ST1); end
					i2cbe_pkg::CMD_STOP: begin sda = 1'b0; go(i2cbe_pkg::ST_SP1); end
					i2cbe_pkg::CMD_WRITE: begin
						shreg   = it.tx_byte;
						bit_cnt = '0;
						sda     = it.tx_byte[i2cbe_pkg::ByteW-1];
						go(i2cbe_pkg::ST_WHI);
					end
					i2cbe_pkg::CMD_READ: begin
						shreg   = '0;
						bit_cnt = '0;
						ack_bit = it.send_nack;
						sda_en  = 1'b0;
						go(i2cbe_pkg::ST_RNEXT);
					end
					i2cbe_pkg::CMD_RELEASE: begin
						sda_en = 1'b0;
						scl_en = 1'b0;
						done   = 1'b1;
					end
					default: ;
				endcase
			end else if (timer > i2cbe_pkg::TimerW'(1)) begin
				timer = timer - i2cbe_pkg::TimerW'(1);
			end else if (advance(it.sda_in)) begin
				done = 1'b1;
			end
			want.scl_level = scl;
			want.sda_level = sda;
			want.sda_drive = sda_en;
			want.scl_drive = scl_en;
			want.busy_res  = (step != i2cbe_pkg::ST_IDLE);
			want.done_res  = done;
			want.nacked    = nack_flag;
			want.rx_byte   = rx_hold;
			pending_results.push_back(want);
		endfunction

		function void compare_field(string name, logic [i2cbe_pkg::ByteW-1:0] want,
				logic [i2cbe_pkg::ByteW-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		// one result transfer against the oldest expectation
		function void check_result(i2cbe_pkg::res_t got);
			i2cbe_pkg::res_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0h", $time, got);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			compare_field("scl_level", i2cbe_pkg::ByteW'(want.scl_level),
				i2cbe_pkg::ByteW'(got.scl_level));
			compare_field("sda_level", i2cbe_pkg::ByteW'(want.sda_level),
				i2cbe_pkg::ByteW'(got.sda_level));
			compare_field("sda_drive", i2cbe_pkg::ByteW'(want.sda_drive),
				i2cbe_pkg::ByteW'(got.sda_drive));
			compare_field("scl_drive", i2cbe_pkg::ByteW'(want.scl_drive),
				i2cbe_pkg::ByteW'(got.scl_drive));
			compare_field("busy_res", i2cbe_pkg::ByteW'(want.busy_res),
				i2cbe_pkg::ByteW'(got.busy_res));
			compare_field("done_res", i2cbe_pkg::ByteW'(want.done_res),
				i2cbe_pkg::ByteW'(got.done_res));
			compare_field("nacked", i2cbe_pkg::ByteW'(want.nacked),
				i2cbe_pkg::ByteW'(got.nacked));
			compare_field("rx_byte", want.rx_byte, got.rx_byte);
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_wr_en;
	logic [i2cbe_pkg::TimerW-1:0] cfg_wr_data;
	int                           idle_mode;
	int                           stall_cycles;
	int                           phase_writes;
	engine_scoreboard             sb;

	i2cbe_tick_if tick_ch();
	i2cbe_res_if  res_ch();

	i2c_master_bit_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick_ch),
		.result      (res_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// clock, period 20
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit sender_idles();
		case (idle_mode)
			IdleSender: return $urandom_range(0, 99) < 86;
			IdleBoth:   return $urandom_range(0, 99) < 19;
			default:    return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IdleReceiver: return $urandom_range(0, 99) < 86;
			IdleBoth:     return $urandom_range(0, 99) < 19;
			default:      return 1'b0;
		endcase
	endfunction

	function automatic logic pick_sda(int sda_mode);
		case (sda_mode)
			SdaLow:  return 1'b0;
			SdaHigh: return 1'b1;
			default: return 1'($urandom);
		endcase
	endfunction

	// result side: ready changes on the falling edge
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= !receiver_stalls();
		end
	end

	// result check and stall watchdog on the rising edge
	always @(posedge clk) begin : monitor
		i2cbe_pkg::res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.scl_level = res_ch.scl_level;
			got.sda_level = res_ch.sda_level;
			got.sda_drive = res_ch.sda_drive;
			got.scl_drive = res_ch.scl_drive;
			got.busy_res  = res_ch.busy_res;
			got.done_res  = res_ch.done_res;
			got.nacked    = res_ch.nacked;
			got.rx_byte   = res_ch.rx_byte;
			sb.check_result(got);
		end
		if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : watchdog
		wait (stall_cycles >= StallLimit);
		$display("%0t: no transfer for %0d cycles", $time, StallLimit);
		$display("Verification failed");
		$finish;
	end

	// one tick transfer; called and returns at a falling edge
	task automatic send_tick(input i2cbe_pkg::item_t it);
		while (sender_idles()) begin
			tick_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tick_ch.cmd       <= it.cmd;
		tick_ch.tx_byte   <= it.tx_byte;
		tick_ch.send_nack <= it.send_nack;
		tick_ch.sda_in    <= it.sda_in;
		tick_ch.valid     <= 1'b1;
		do
			@(posedge clk);
		while (!tick_ch.ready);
		sb.note_tick(it);
		@(negedge clk);
	endtask

	// hold off ticks until every expected result has arrived
	task automatic finish_transfers();
		tick_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_phase(input logic [i2cbe_pkg::TimerW-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		sb.set_phase(value);
		phase_writes++;
	endtask

	// one command tick, then ticks until the engine is idle again
	task automatic run_cmd(input logic [i2cbe_pkg::CmdW-1:0] code,
			input logic [i2cbe_pkg::ByteW-1:0] data,
			input logic nack, input int sda_mode, input bit junk);
		i2cbe_pkg::item_t it;
		it.cmd       = code;
		it.tx_byte   = data;
		it.send_nack = nack;
		it.sda_in    = pick_sda(sda_mode);
		send_tick(it);
		while (!sb.idle()) begin
			it.cmd       = junk ? i2cbe_pkg::CmdW'($urandom_range(0, 7)) : i2cbe_pkg::CMD_NONE;
			it.tx_byte   = i2cbe_pkg::ByteW'($urandom);
			it.send_nack = 1'($urandom);
			it.sda_in    = pick_sda(sda_mode);
			send_tick(it);
		end
	endtask

	// mostly real commands when idle, mostly empty ticks while busy
	function automatic i2cbe_pkg::item_t random_tick();
		i2cbe_pkg::item_t it;
		int pick;
		it.tx_byte   = i2cbe_pkg::ByteW'($urandom);
		it.send_nack = 1'($urandom);
		it.sda_in    = 1'($urandom);
		if (sb.idle()) begin
			pick = $urandom_range(0, 99);
			if (pick < 22)      it.cmd = i2cbe_pkg::CMD_START;
			else if (pick < 51) it.cmd = i2cbe_pkg::CMD_WRITE;
			else if (pick < 76) it.cmd = i2cbe_pkg::CMD_READ;
			else if (pick < 92) it.cmd = i2cbe_pkg::CMD_STOP;
			else if (pick < 93) it.cmd = i2cbe_pkg::CMD_RELEASE;
			else if (pick < 97) it.cmd = i2cbe_pkg::CMD_NONE;
			else                it.cmd = ($urandom_range(0, 1) != 0) ? CmdSpare6 : CmdSpare7;
		end else begin
			it.cmd = ($urandom_range(0, 9) == 0) ? i2cbe_pkg::CmdW'($urandom_range(0, 7)) :
				i2cbe_pkg::CMD_NONE;
		end
		return it;
	endfunction

	task automatic run_random(input int count, input int mode,
			input logic [i2cbe_pkg::TimerW-1:0] len, input bit pause_mid);
		i2cbe_pkg::item_t it;
		int done_cnt;
		bit useful;
		done_cnt = 0;
		finish_transfers();
		write_phase(len);
		idle_mode = mode;
		while (done_cnt < count) begin
			it     = random_tick();
			useful = !sb.idle() || (it.cmd inside {i2cbe_pkg::CMD_START, i2cbe_pkg::CMD_STOP,
				i2cbe_pkg::CMD_WRITE, i2cbe_pkg::CMD_READ, i2cbe_pkg::CMD_RELEASE});
			send_tick(it);
			if (useful)
				done_cnt++;
			// sender holds off until the engine has delivered everything
			if (pause_mid && done_cnt == count / 2)
				finish_transfers();
		end
	endtask

	initial begin : stimulus
		logic [i2cbe_pkg::TimerW-1:0] lens[8];
		tick_ch.valid     = 1'b0;
		tick_ch.cmd       = i2cbe_pkg::CMD_NONE;
		tick_ch.tx_byte   = '0;
		tick_ch.send_nack = 1'b0;
		tick_ch.sda_in    = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		arst_n            = 1'b0;
		idle_mode         = IdleNone;
		stall_cycles      = 0;
		phase_writes      = 0;
		lens              = '{8'd1, 8'd2, 8'd3, 8'd1, 8'd4, 8'd2, 8'd1, 8'd3};
		sb                = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset phase length, idle ticks, spare codes and a start
		run_cmd(i2cbe_pkg::CMD_NONE, 8'h00, 1'b0, SdaLow, 1'b0);
		run_cmd(CmdSpare6, 8'hFF, 1'b1, SdaHigh, 1'b0);
		run_cmd(CmdSpare7, 8'h00, 1'b0, SdaLow, 1'b0);
		run_cmd(i2cbe_pkg::CMD_START, 8'h00, 1'b0, SdaHigh, 1'b1);

		// zero phase length acts as one
		finish_transfers();
		write_phase(8'd0);
		run_cmd(i2cbe_pkg::CMD_WRITE, 8'hFF, 1'b0, SdaLow, 1'b1);
		run_cmd(i2cbe_pkg::CMD_WRITE, 8'h00, 1'b1, SdaHigh, 1'b1);
		run_cmd(i2cbe_pkg::CMD_WRITE, 8'hA5, 1'b0, SdaRand, 1'b0);
		run_cmd(i2cbe_pkg::CMD_READ, 8'h00, 1'b0, SdaHigh, 1'b1);
		run_cmd(i2cbe_pkg::CMD_READ, 8'hFF, 1'b1, SdaLow, 1'b0);
		run_cmd(i2cbe_pkg::CMD_READ, 8'h5A, 1'b1, SdaRand, 1'b1);
		run_cmd(i2cbe_pkg::CMD_STOP, 8'h00, 1'b0, SdaRand, 1'b1);
		run_cmd(i2cbe_pkg::CMD_START, 8'h3C, 1'b1, SdaRand, 1'b0);

		// long phase
		finish_transfers();
		write_phase(8'd30);
		run_cmd(i2cbe_pkg::CMD_START, i2cbe_pkg::ByteW'($urandom), 1'($urandom), SdaRand,
			1'b1);

		for (int p = 0; p < 8; p++)
			run_random(PhaseTicks, p % 4, lens[p], p == 2);

		// release and the commands after it
		finish_transfers();
		write_phase(8'd1);
		idle_mode = IdleBoth;
		run_cmd(i2cbe_pkg::CMD_RELEASE, 8'h00, 1'b0, SdaRand, 1'b0);
		run_cmd(i2cbe_pkg::CMD_START, 8'h00, 1'b0, SdaRand, 1'b1);
		run_cmd(i2cbe_pkg::CMD_WRITE, 8'h81, 1'b0, SdaLow, 1'b1);
		run_cmd(i2cbe_pkg::CMD_READ, 8'h00, 1'b1, SdaRand, 1'b1);
		run_cmd(i2cbe_pkg::CMD_STOP, 8'h00, 1'b0, SdaRand, 1'b0);

		finish_transfers();
		repeat (8) @(negedge clk);
		$display("ran %0d ticks over %0d phase lengths, %0d results checked, %0d write nacks",
			sb.ticks, phase_writes, sb.checked, sb.nack_events);
		$display("commands start %0d stop %0d write %0d read %0d release %0d",
			sb.cmd_seen[i2cbe_pkg::CMD_START], sb.cmd_seen[i2cbe_pkg::CMD_STOP],
			sb.cmd_seen[i2cbe_pkg::CMD_WRITE], sb.cmd_seen[i2cbe_pkg::CMD_READ],
			sb.cmd_seen[i2cbe_pkg::CMD_RELEASE]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* i2c_master_bit_engine.f */
rtl/i2cbe_pkg.sv
rtl/i2cbe_tick_if.sv
rtl/i2cbe_res_if.sv
rtl/i2cbe_core.sv
rtl/i2c_master_bit_engine.sv
tb/testbench.sv
